// ===== rtl/core/mrcg_pkg.sv =====
// ----------------------------------------------------------------------------
// mrcg_pkg
// Shared types and constants of the mask run copy code generator.
// ----------------------------------------------------------------------------
package mrcg_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_MASK_PITCH    = 3'd0;
    localparam logic [2:0] CFG_SOURCE_PITCH  = 3'd1;
    localparam logic [2:0] CFG_WINDOW_X      = 3'd2;
    localparam logic [2:0] CFG_WINDOW_Y      = 3'd3;
    localparam logic [2:0] CFG_WINDOW_WIDTH  = 3'd4;
    localparam logic [2:0] CFG_WINDOW_HEIGHT = 3'd5;
    localparam logic [2:0] CFG_BANKED_MODE   = 3'd6;
    localparam logic [2:0] CFG_PAGE_ROUTINE  = 3'd7;

    // Most code bytes kept for one pixel
    localparam logic [6:0] MAX_BURST = 7'd64;

    // Base of the banked video window
    localparam logic [31:0] BANK_BASE = 32'h000A_0000;

    typedef struct packed {
        logic [15:0] mask_pitch;
        logic [15:0] source_pitch;
        logic [11:0] window_x;
        logic [11:0] window_y;
        logic [11:0] window_width;
        logic [11:0] window_height;
        logic        banked_mode;
        logic [31:0] page_routine_address;
    } cfg_t;

    // Instructions the generator can emit
    typedef enum logic [3:0] {
        INS_ADD_ESI,
        INS_ADD_EDI,
        INS_MOV_EBX,
        INS_MOV_EAX,
        INS_MOV_EDI,
        INS_MOV_ECX,
        INS_CALL_EBX,
        INS_REP_MOVSD,
        INS_MOVSD,
        INS_MOVSW,
        INS_MOVSW_MOVSB,
        INS_MOVSB,
        INS_RET
    } ins_t;

    // Immediate sources
    typedef enum logic [3:0] {
        IMM_ZERO,
        IMM_ROUTINE,
        IMM_DSRC,
        IMM_DDST,
        IMM_PAGE1,
        IMM_PAGE2,
        IMM_EDI1,
        IMM_EDI0,
        IMM_BLOCKS
    } imm_sel_t;

    // Copy count sources
    typedef enum logic [1:0] {
        CNT_N,
        CNT_FIRST,
        CNT_REST
    } cnt_sel_t;

    typedef struct packed {
        logic [2:0]  len;
        logic [47:0] bytes;
    } ins_img_t;

    typedef struct packed {
        logic     load;
        logic     hdr_init;
        logic     pix;
        logic     lin_add_ddst;
        logic     calc_p2;
        logic     set_page1;
        logic     set_page2;
        logic     lin_add_n;
        logic     run_end;
        logic     load_cnt;
        cnt_sel_t cnt_sel;
        logic     emit;
        ins_t     ins;
        imm_sel_t imm_sel;
        logic     flush;
    } cmd_t;

    typedef struct packed {
        logic       emit_idle;
        logic       banked;
        logic       first_pix;
        logic       dsrc_pos;
        logic       ddst_pos;
        logic       run_pending;
        logic       last;
        logic       split;
        logic       page_diff;
        logic       cnt_ge4;
        logic       blocks_one;
        logic [1:0] tail;
        logic       rest_nz;
        logic       flush_ok;
    } status_t;

    // Byte image of one instruction, first byte in the low bits
    function automatic ins_img_t ins_image(ins_t ins, logic [31:0] imm);
        ins_img_t img;
        img = '0;
        unique case (ins)
            INS_ADD_ESI:     img = '{len: 3'd6, bytes: {imm, 8'hC6, 8'h81}};
            INS_ADD_EDI:     img = '{len: 3'd6, bytes: {imm, 8'hC7, 8'h81}};
            INS_MOV_EBX:     img = '{len: 3'd5, bytes: {8'h00, imm, 8'hBB}};
            INS_MOV_EAX:     img = '{len: 3'd5, bytes: {8'h00, imm, 8'hB8}};
            INS_MOV_EDI:     img = '{len: 3'd5, bytes: {8'h00, imm, 8'hBF}};
            INS_MOV_ECX:     img = '{len: 3'd5, bytes: {8'h00, imm, 8'hB9}};
            INS_CALL_EBX:    img = '{len: 3'd2, bytes: {32'h0, 8'hD3, 8'hFF}};
            INS_REP_MOVSD:   img = '{len: 3'd2, bytes: {32'h0, 8'hA5, 8'hF3}};
            INS_MOVSD:       img = '{len: 3'd1, bytes: {40'h0, 8'hA5}};
            INS_MOVSW:       img = '{len: 3'd2, bytes: {32'h0, 8'hA5, 8'h66}};
            INS_MOVSW_MOVSB: img = '{len: 3'd3, bytes: {24'h0, 8'hA4, 8'hA5, 8'h66}};
            INS_MOVSB:       img = '{len: 3'd1, bytes: {40'h0, 8'hA4}};
            INS_RET:         img = '{len: 3'd1, bytes: {40'h0, 8'hC3}};
            default:         img = '0;
        endcase
        return img;
    endfunction

endpackage

// ===== rtl/core/mask_run_copy_code_generator_top.sv =====
// ----------------------------------------------------------------------------
// mask_run_copy_code_generator_top
// Turns a window of mask pixels into a byte stream of x86 copy code.
//
//   channel   signals                                   direction
//   input     in_valid, in_stall, mask_pixel            pixel words in
//   output    out_valid, out_stall, code_byte,          code words out
//             last_of_burst, end_of_program
//   config    cfg_write, cfg_index, cfg_data            register writes
//
// A pixel that ends no run passes the accept, update, check and flush steps.
// A run end adds the sequencer steps that emit its code bytes; the banked
// header adds 12 bytes, RET 1 byte.
// in_stall is high from the accept until the last code word sits in the
// output register; out_stall holds the emitter and so lengthens the pixel.
// Reset clears the position and run state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module mask_run_copy_code_generator_top
    import mrcg_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  mask_pixel,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  code_byte,
    output logic        last_of_burst,
    output logic        end_of_program
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t st;

    // Configuration registers
    mrcg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sequencer
    mrcg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // Datapath and output word
    mrcg_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .cmd            (cmd),
        .st             (st),
        .mask_pixel     (mask_pixel),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .code_byte      (code_byte),
        .last_of_burst  (last_of_burst),
        .end_of_program (end_of_program)
    );

endmodule

// ===== rtl/core/mrcg_cfg.sv =====
// ----------------------------------------------------------------------------
// mrcg_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module mrcg_cfg
    import mrcg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mask_pitch           <= 16'd320;
            cfg_reg.source_pitch         <= 16'd320;
            cfg_reg.window_x             <= 12'd0;
            cfg_reg.window_y             <= 12'd0;
            cfg_reg.window_width         <= 12'd320;
            cfg_reg.window_height        <= 12'd200;
            cfg_reg.banked_mode          <= 1'b0;
            cfg_reg.page_routine_address <= 32'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_MASK_PITCH:    cfg_reg.mask_pitch           <= cfg_data[15:0];
                CFG_SOURCE_PITCH:  cfg_reg.source_pitch         <= cfg_data[15:0];
                CFG_WINDOW_X:      cfg_reg.window_x             <= cfg_data[11:0];
                CFG_WINDOW_Y:      cfg_reg.window_y             <= cfg_data[11:0];
                CFG_WINDOW_WIDTH:  cfg_reg.window_width         <= cfg_data[11:0];
                CFG_WINDOW_HEIGHT: cfg_reg.window_height        <= cfg_data[11:0];
                CFG_BANKED_MODE:   cfg_reg.banked_mode          <= cfg_data[0];
                CFG_PAGE_ROUTINE:  cfg_reg.page_routine_address <= cfg_data;
                default:           cfg_reg.mask_pitch           <= cfg_reg.mask_pitch;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/mrcg_datapath.sv =====
// ----------------------------------------------------------------------------
// mrcg_datapath
// Run tracking, address arithmetic, instruction byte emitter and output word.
// ----------------------------------------------------------------------------
module mrcg_datapath
    import mrcg_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  cmd_t        cmd,
    output status_t     st,
    input  logic [7:0]  mask_pixel,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  code_byte,
    output logic        last_of_burst,
    output logic        end_of_program
);

    localparam int LEN_W = COORD_BITS + 1;

    typedef enum logic [1:0] {
        RUN_OFF,
        RUN_GAP,
        RUN_ON
    } mode_t;

    // Pixel position and run state
    logic [COORD_BITS-1:0] col_reg, row_reg;
    mode_t                 mode_reg;
    logic [31:0]           rs_src_reg, rs_dst_reg;
    logic [LEN_W-1:0]      len_reg;
    logic [31:0]           src_cur_reg, dst_cur_reg, src_off_reg;
    logic [15:0]           cur_page_reg;
    logic [31:0]           lin_reg;
    logic                  pend_reg, last_reg;

    // Per pixel work values
    logic [7:0]            pixel_reg;
    logic [31:0]           dest_reg;
    logic [15:0]           p2_reg;
    logic [16:0]           first_reg;
    logic                  split_reg;
    logic [LEN_W-1:0]      cnt_reg;

    // Emitter and output
    logic [47:0]           sh_reg;
    logic [2:0]            left_reg;
    logic [7:0]            hold_reg;
    logic                  hold_v_reg;
    logic [6:0]            bcnt_reg;
    logic                  out_v_reg;
    logic [7:0]            out_byte_reg;
    logic                  out_last_reg, out_eop_reg;

    // Window geometry, zero size taken as one
    logic [15:0]           w16, h16, wx16, wy16;
    logic [COORD_BITS-1:0] w_m, h_m, w_eff, h_eff;
    logic [COORD_BITS:0]   x, y, col_inc, row_inc;
    logic [47:0]           prod;
    logic                  trans, row_end, is_last;

    assign w16   = {4'd0, cfg.window_width};
    assign h16   = {4'd0, cfg.window_height};
    assign wx16  = {4'd0, cfg.window_x};
    assign wy16  = {4'd0, cfg.window_y};
    assign w_m   = w16[COORD_BITS-1:0];
    assign h_m   = h16[COORD_BITS-1:0];
    assign w_eff = (w_m == '0) ? {{(COORD_BITS-1){1'b0}}, 1'b1} : w_m;
    assign h_eff = (h_m == '0) ? {{(COORD_BITS-1){1'b0}}, 1'b1} : h_m;

    assign x       = {1'b0, wx16[COORD_BITS-1:0]} + {1'b0, col_reg};
    assign y       = {1'b0, wy16[COORD_BITS-1:0]} + {1'b0, row_reg};
    assign prod    = 48'(y) * 48'(cfg.mask_pitch);
    assign col_inc = {1'b0, col_reg} + {{COORD_BITS{1'b0}}, 1'b1};
    assign row_inc = {1'b0, row_reg} + {{COORD_BITS{1'b0}}, 1'b1};
    assign trans   = (pixel_reg == 8'hFF);
    assign row_end = (col_inc >= {1'b0, w_eff});
    assign is_last = row_end && (row_inc >= {1'b0, h_eff});

    // Run arithmetic
    logic [31:0] n32, dsrc, ddst, lin_n, imm;
    logic [16:0] n17, first_next, rest17;
    logic [LEN_W-1:0] cnt_next;

    assign n32        = 32'(len_reg);
    assign n17        = 17'(len_reg);
    assign dsrc       = rs_src_reg - src_cur_reg;
    assign ddst       = rs_dst_reg - dst_cur_reg;
    assign lin_n      = lin_reg + n32;
    assign first_next = 17'h10000 - {1'b0, lin_reg[15:0]};
    assign rest17     = n17 - first_reg;

    always_comb
    begin
        unique case (cmd.cnt_sel)
            CNT_N:     cnt_next = len_reg;
            CNT_FIRST: cnt_next = first_reg[LEN_W-1:0];
            CNT_REST:  cnt_next = rest17[LEN_W-1:0];
            default:   cnt_next = len_reg;
        endcase
    end

    // Select the immediate
    always_comb
    begin
        unique case (cmd.imm_sel)
            IMM_ZERO:    imm = 32'd0;
            IMM_ROUTINE: imm = cfg.page_routine_address;
            IMM_DSRC:    imm = dsrc;
            IMM_DDST:    imm = ddst;
            IMM_PAGE1:   imm = {16'd0, lin_reg[31:16]};
            IMM_PAGE2:   imm = {16'd0, p2_reg};
            IMM_EDI1:    imm = BANK_BASE + {16'd0, lin_reg[15:0]};
            IMM_EDI0:    imm = BANK_BASE;
            IMM_BLOCKS:  imm = 32'(cnt_reg[LEN_W-1:2]);
            default:     imm = 32'd0;
        endcase
    end

    // Latch the pixel and its destination address, the page split values and the copy count
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pixel_reg <= mask_pixel;
            dest_reg  <= prod[31:0] + 32'(x);
        end
        if (cmd.calc_p2)
        begin
            p2_reg    <= lin_n[31:16];
            first_reg <= first_next;
        end
        if (cmd.load_cnt)
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Advance the run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            mode_reg     <= RUN_OFF;
            rs_src_reg   <= '0;
            rs_dst_reg   <= '0;
            len_reg      <= '0;
            src_cur_reg  <= '0;
            dst_cur_reg  <= '0;
            src_off_reg  <= '0;
            cur_page_reg <= '0;
            lin_reg      <= '0;
            pend_reg     <= 1'b0;
            last_reg     <= 1'b0;
            split_reg    <= 1'b0;
        end
        else if (cmd.flush && st.flush_ok && last_reg)
        begin
            // program done: back to the start state
            col_reg      <= '0;
            row_reg      <= '0;
            mode_reg     <= RUN_OFF;
            rs_src_reg   <= '0;
            rs_dst_reg   <= '0;
            len_reg      <= '0;
            src_cur_reg  <= '0;
            dst_cur_reg  <= '0;
            src_off_reg  <= '0;
            cur_page_reg <= '0;
            lin_reg      <= '0;
            last_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.hdr_init)
            begin
                cur_page_reg <= '0;
                lin_reg      <= '0;
            end
            if (cmd.pix)
            begin
                if (trans)
                begin
                    if (mode_reg != RUN_ON)
                    begin
                        rs_src_reg <= src_off_reg;
                        rs_dst_reg <= dest_reg;
                        len_reg    <= {{(LEN_W-1){1'b0}}, 1'b1};
                    end
                    else
                    begin
                        len_reg <= len_reg + {{(LEN_W-1){1'b0}}, 1'b1};
                    end
                end
                pend_reg <= (!trans && mode_reg == RUN_ON) || (row_end && trans);
                last_reg <= is_last;
                if (row_end)
                begin
                    mode_reg    <= RUN_OFF;
                    src_off_reg <= src_off_reg + 32'd1 + 32'(cfg.source_pitch)
                                   - 32'(w_eff);
                    col_reg     <= '0;
                    if (!is_last)
                    begin
                        row_reg <= row_inc[COORD_BITS-1:0];
                    end
                end
                else
                begin
                    mode_reg    <= trans ? RUN_ON : RUN_GAP;
                    src_off_reg <= src_off_reg + 32'd1;
                    col_reg     <= col_inc[COORD_BITS-1:0];
                end
            end
            if (cmd.lin_add_ddst)
            begin
                lin_reg <= lin_reg + ddst;
            end
            if (cmd.calc_p2)
            begin
                split_reg <= (lin_reg[31:16] != lin_n[31:16]);
            end
            if (cmd.set_page1)
            begin
                cur_page_reg <= lin_reg[31:16];
            end
            if (cmd.set_page2)
            begin
                cur_page_reg <= p2_reg;
            end
            if (cmd.lin_add_n)
            begin
                lin_reg <= lin_n;
            end
            if (cmd.run_end)
            begin
                src_cur_reg <= rs_src_reg + n32;
                dst_cur_reg <= rs_dst_reg + n32;
            end
        end
    end

    // Emitter: shift out one byte per cycle when the hold stage can move
    ins_img_t img;
    logic     out_free, adv, keep, flush_move;

    assign img        = ins_image(cmd.ins, imm);
    assign out_free   = !out_v_reg || !out_stall;
    assign adv        = (left_reg != 3'd0) && (!hold_v_reg || out_free);
    assign keep       = adv && (bcnt_reg < MAX_BURST);
    assign flush_move = cmd.flush && hold_v_reg && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= 3'd0;
            hold_v_reg <= 1'b0;
            bcnt_reg   <= 7'd0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                bcnt_reg <= 7'd0;
            end
            else if (keep)
            begin
                bcnt_reg <= bcnt_reg + 7'd1;
            end

            if (cmd.emit)
            begin
                left_reg <= img.len;
            end
            else if (adv)
            begin
                left_reg <= left_reg - 3'd1;
            end

            if (keep)
            begin
                hold_v_reg <= 1'b1;
            end
            else if (flush_move)
            begin
                hold_v_reg <= 1'b0;
            end

            if ((keep && hold_v_reg) || flush_move)
            begin
                out_v_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    // Shift register, hold stage and output word payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            sh_reg <= img.bytes;
        end
        else if (adv)
        begin
            sh_reg <= {8'd0, sh_reg[47:8]};
        end
        if (keep)
        begin
            hold_reg <= sh_reg[7:0];
        end
        if (keep && hold_v_reg)
        begin
            out_byte_reg <= hold_reg;
            out_last_reg <= 1'b0;
            out_eop_reg  <= 1'b0;
        end
        else if (flush_move)
        begin
            out_byte_reg <= hold_reg;
            out_last_reg <= 1'b1;
            out_eop_reg  <= last_reg;
        end
    end

    assign out_valid      = out_v_reg;
    assign code_byte      = out_byte_reg;
    assign last_of_burst  = out_last_reg;
    assign end_of_program = out_eop_reg;

    // Status to the controller
    assign st.emit_idle   = (left_reg == 3'd0);
    assign st.banked      = cfg.banked_mode;
    assign st.first_pix   = (col_reg == '0) && (row_reg == '0);
    assign st.dsrc_pos    = (dsrc != 32'd0) && !dsrc[31];
    assign st.ddst_pos    = (ddst != 32'd0) && !ddst[31];
    assign st.run_pending = pend_reg;
    assign st.last        = last_reg;
    assign st.split       = split_reg;
    assign st.page_diff   = (lin_reg[31:16] != cur_page_reg);
    assign st.cnt_ge4     = (cnt_reg[LEN_W-1:2] != '0);
    assign st.blocks_one  = (cnt_reg[LEN_W-1:2] == {{(LEN_W-3){1'b0}}, 1'b1});
    assign st.tail        = cnt_reg[1:0];
    assign st.rest_nz     = (n17 > first_reg);
    assign st.flush_ok    = !hold_v_reg || out_free;

endmodule

// ===== rtl/core/mrcg_ctrl.sv =====
// ----------------------------------------------------------------------------
// mrcg_ctrl
// Sequencer: walks header, run end, copy, RET and flush steps of one pixel.
// ----------------------------------------------------------------------------
module mrcg_ctrl
    import mrcg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t st,
    output cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_HDR_EBX,
        S_HDR_EAX,
        S_HDR_CALL,
        S_PIX,
        S_CHK,
        S_R_SRC,
        S_R_DST,
        S_R_LIN,
        S_R_P2,
        S_R_SEL1,
        S_R_CALL1,
        S_R_EDI1,
        S_R_SEL2,
        S_R_CALL2,
        S_R_EDI2,
        S_R_LEND,
        S_R_END,
        S_C_MAIN,
        S_C_REP,
        S_C_TAIL,
        S_RET,
        S_FLUSH
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    // Hold state and copy return point
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_R_END;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        cmd         = '0;
        cmd.ins     = INS_RET;
        cmd.imm_sel = IMM_ZERO;
        cmd.cnt_sel = CNT_N;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (st.first_pix && st.banked) ? S_HDR_EBX : S_PIX;
                end
            end
            S_HDR_EBX:
            begin
                if (st.emit_idle)
                begin
                    cmd.emit    = 1'b1;
                    cmd.ins     = INS_MOV_EBX;
                    cmd.imm_sel = IMM_ROUTINE;
                    state_next  = S_HDR_EAX;
                end
            end
            S_HDR_EAX:
            begin
                if (st.emit_idle)
                begin
                    cmd.emit    = 1'b1;
                    cmd.ins     = INS_MOV_EAX;
                    cmd.imm_sel = IMM_ZERO;
                    state_next  = S_HDR_CALL;
                end
            end
            S_HDR_CALL:
            begin
                if (st.emit_idle)
                begin
                    cmd.emit     = 1'b1;
                    cmd.ins      = INS_CALL_EBX;
                    cmd.hdr_init = 1'b1;
                    state_next   = S_PIX;
                end
            end
            S_PIX:
            begin
                cmd.pix    = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                priority if (st.run_pending)
                    state_next = S_R_SRC;
                else if (st.last)
                    state_next = S_RET;
                else
                    state_next = S_FLUSH;
            end
            S_R_SRC:
            begin
                if (st.emit_idle)
                begin
                    if (st.dsrc_pos)
                    begin
                        cmd.emit    = 1'b1;
                        cmd.ins     = INS_ADD_ESI;
                        cmd.imm_sel = IMM_DSRC;
                    end
                    state_next = st.banked ? S_R_LIN : S_R_DST;
                end
            end
            S_R_DST:
            begin
                if (st.emit_idle)
                begin
                    if (st.ddst_pos)
                    begin
                        cmd.emit    = 1'b1;
                        cmd.ins     = INS_ADD_EDI;
                        cmd.imm_sel = IMM_DDST;
                    end
                    cmd.load_cnt = 1'b1;
                    cmd.cnt_sel  = CNT_N;
                    ret_next     = S_R_END;
                    state_next   = S_C_MAIN;
                end
            end
            S_R_LIN:
            begin
                cmd.lin_add_ddst = 1'b1;
                state_next       = S_R_P2;
            end
            S_R_P2:
            begin
                cmd.calc_p2 = 1'b1;
                state_next  = S_R_SEL1;
            end
            S_R_SEL1:
            begin
                if (st.emit_idle)
                begin
                    if (st.page_diff)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.ins       = INS_MOV_EAX;
                        cmd.imm_sel   = IMM_PAGE1;
                        cmd.set_page1 = 1'b1;
                        state_next    = S_R_CALL1;
                    end
                    else
                    begin
                        state_next = S_R_EDI1;
                    end
                end
            end
            S_R_CALL1:
            begin
                if (st.emit_idle)
                begin
                    cmd.emit   = 1'b1;
                    cmd.ins    = INS_CALL_EBX;
                    state_next = S_R_EDI1;
                end
            end
            S_R_EDI1:
            begin
                if (st.emit_idle)
                begin
                    cmd.emit     = 1'b1;
                    cmd.ins      = INS_MOV_EDI;
                    cmd.imm_sel  = IMM_EDI1;
                    cmd.load_cnt = 1'b1;
                    cmd.cnt_sel  = st.split ? CNT_FIRST : CNT_N;
                    ret_next     = st.split ? S_R_SEL2 : S_R_LEND;
                    state_next   = S_C_MAIN;
                end
            end
            S_R_SEL2:
            begin
                if (st.emit_idle)
                begin
                    cmd.emit      = 1'b1;
                    cmd.ins       = INS_MOV_EAX;
                    cmd.imm_sel   = IMM_PAGE2;
                    cmd.set_page2 = 1'b1;
                    state_next    = S_R_CALL2;
                end
            end
            S_R_CALL2:
            begin
                if (st.emit_idle)
                begin
                    cmd.emit   = 1'b1;
                    cmd.ins    = INS_CALL_EBX;
                    state_next = S_R_EDI2;
                end
            end
            S_R_EDI2:
            begin
                if (st.emit_idle)
                begin
                    cmd.emit     = 1'b1;
                    cmd.ins      = INS_MOV_EDI;
                    cmd.imm_sel  = IMM_EDI0;
                    cmd.load_cnt = 1'b1;
                    cmd.cnt_sel  = CNT_REST;
                    ret_next     = S_R_LEND;
                    state_next   = st.rest_nz ? S_C_MAIN : S_R_LEND;
                end
            end
            S_R_LEND:
            begin
                cmd.lin_add_n = 1'b1;
                state_next    = S_R_END;
            end
            S_R_END:
            begin
                cmd.run_end = 1'b1;
                state_next  = st.last ? S_RET : S_FLUSH;
            end
            S_C_MAIN:
            begin
                if (st.emit_idle)
                begin
                    if (st.cnt_ge4)
                    begin
                        cmd.emit = 1'b1;
                        if (st.blocks_one)
                        begin
                            cmd.ins    = INS_MOVSD;
                            state_next = S_C_TAIL;
                        end
                        else
                        begin
                            cmd.ins     = INS_MOV_ECX;
                            cmd.imm_sel = IMM_BLOCKS;
                            state_next  = S_C_REP;
                        end
                    end
                    else
                    begin
                        state_next = S_C_TAIL;
                    end
                end
            end
            S_C_REP:
            begin
                if (st.emit_idle)
                begin
                    cmd.emit   = 1'b1;
                    cmd.ins    = INS_REP_MOVSD;
                    state_next = S_C_TAIL;
                end
            end
            S_C_TAIL:
            begin
                if (st.emit_idle)
                begin
                    unique case (st.tail)
                        2'd1:
                        begin
                            cmd.emit = 1'b1;
                            cmd.ins  = INS_MOVSB;
                        end
                        2'd2:
                        begin
                            cmd.emit = 1'b1;
                            cmd.ins  = INS_MOVSW;
                        end
                        2'd3:
                        begin
                            cmd.emit = 1'b1;
                            cmd.ins  = INS_MOVSW_MOVSB;
                        end
                        default:
                        begin
                            cmd.emit = 1'b0;
                        end
                    endcase
                    state_next = ret_reg;
                end
            end
            S_RET:
            begin
                if (st.emit_idle)
                begin
                    cmd.emit   = 1'b1;
                    cmd.ins    = INS_RET;
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (st.emit_idle)
                begin
                    cmd.flush = 1'b1;
                    if (st.flush_ok)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
